// ===== rtl/core/itk_pkg.sv =====
// Shared types, constants and arithmetic helpers of the IMU tilt Kalman filter core.
package itk_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_W     = 28;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 31;

    localparam logic signed [31:0] DEG90_Q16   = 32'sd5898240;
    localparam logic signed [31:0] ANGLE_LIMIT = 32'sd23592960;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN     = 3'd4;

    typedef struct packed {
        logic [30:0] angle_noise;
        logic [30:0] bias_noise;
        logic [30:0] measure_noise;
        logic [24:0] time_step;
        logic [24:0] gyro_gain;
    } kf_cfg_t;

    typedef struct packed {
        logic               busy;
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } lane_status_t;

    typedef enum logic [2:0] {
        FE_IDLE, FE_SQUARE, FE_ROOT, FE_WAIT, FE_PITCH, FE_FILTER, FE_OUT
    } fe_state_t;

    typedef enum logic [2:0] {
        LN_IDLE, LN_MUL, LN_ACC, LN_DIV0, LN_DIV1
    } lane_state_t;

    typedef enum logic [3:0] {
        OP_RATE, OP_PRED, OP_DP, OP_N00, OP_N11,
        OP_K0Y, OP_K1Y, OP_K0N00, OP_K0N01, OP_K1N00, OP_K1N01
    } lane_op_t;

    // Arctangent of 2^-i in Q16.16 degrees.
    function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117266;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Round to nearest (half up) while dropping s fraction bits.
    function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v,
                                                   input logic [4:0] s);
        logic signed [71:0] half;
        half = 72'sd1 <<< (s - 5'd1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [25:0] clamp_angle(input logic signed [31:0] a);
        logic signed [31:0] v;
        v = a;
        if (v > ANGLE_LIMIT) begin
            v = ANGLE_LIMIT;
        end else if (v < -ANGLE_LIMIT) begin
            v = -ANGLE_LIMIT;
        end
        return v[25:0];
    endfunction

endpackage

// ===== rtl/core/imu_tilt_kalman_filter_core.sv =====
// Top level of the IMU tilt Kalman filter: front-end angle finding, two filter lanes, output beat.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one raw IMU sample per beat: three
//   accelerometer axes and the pitch and roll gyro rates. The master channel (m_tvalid,
//   m_tready, m_tdata) returns one beat per sample with the filtered pitch and roll angles
//   (Q10.16 degrees, held to plus or minus 360) and the two estimated gyro biases.
//   The configuration port writes one filter register per cycle while cfg_wr_en is high;
//   write it only while no sample is in flight.
// Processing:
//   A sample first goes through the squares and the square root of ay^2 + az^2 (two bits a
//   cycle), with the roll CORDIC running alongside, then through the pitch CORDIC (skipped
//   when ay and az are both zero). The two filter lanes then run side by side; in each the
//   two 31-step gain divisions (cut short when the gain saturates) and eleven passes through
//   the shared multiplier dominate. One sample is processed at a time, so a new beat is taken
//   once the previous result has been placed in the output register.
// Reset:
//   aresetn is synchronous and active low. It clears the angles, biases and covariances,
//   loads the default noise, time step and gyro gain values and empties the output register.
// Stall:
//   A result waits in the output register while m_tready is low. The next sample is still
//   accepted and processed; its result waits until the register frees up.
module imu_tilt_kalman_filter_core import itk_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: accel_x, accel_y, accel_z, gyro_pitch_rate, gyro_roll_rate (16 bits each)
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [79:0]           s_tdata,
    // m_tdata: pitch_estimate[25:0], roll_estimate[51:26], pitch_drift[83:52],
    // roll_drift[115:84], zeros above
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [119:0]          m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    fe_state_t state_reg, state_next;

    // Filter registers, loaded with the usual defaults at reset.
    kf_cfg_t cfg_reg;

    // Sample capture.
    logic signed [15:0] ax_reg, ay_reg, az_reg, gp_reg, gr_reg;
    logic [30:0]        sq_y_reg, sq_z_reg;

    // Output beat register.
    logic               m_valid_reg, m_valid_next;
    logic [119:0]       m_data_reg, m_data_next;

    // Front-end units.
    logic               root_start, roll_start, pitch_start, lane_start;
    logic [23:0]        root_val;
    logic               root_busy, roll_busy, pitch_busy;
    logic signed [31:0] roll_angle, pitch_angle;
    logic signed [31:0] pitch_meas;
    logic signed [31:0] pitch_flat;
    logic signed [CORDIC_W-1:0] roll_x, roll_y, pitch_x, pitch_y;
    lane_status_t       pitch_st, roll_st;
    logic               in_beat;

    assign in_beat = s_tvalid && s_tready;
    assign s_tready = (state_reg == FE_IDLE);

    // Configuration writes; indexes past the last register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_noise   <= 31'd16777;
            cfg_reg.bias_noise    <= 31'd50332;
            cfg_reg.measure_noise <= 31'd503316;
            cfg_reg.time_step     <= 25'd167772;
            cfg_reg.gyro_gain     <= 25'd128071;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ANGLE_NOISE:   cfg_reg.angle_noise   <= cfg_wr_data;
                CFG_BIAS_NOISE:    cfg_reg.bias_noise    <= cfg_wr_data;
                CFG_MEASURE_NOISE: cfg_reg.measure_noise <= cfg_wr_data;
                CFG_TIME_STEP:     cfg_reg.time_step     <= cfg_wr_data[24:0];
                CFG_GYRO_GAIN:     cfg_reg.gyro_gain     <= cfg_wr_data[24:0];
                default: begin
                end
            endcase
        end
    end

    // Roll is atan2(ay, az); pitch is atan2(-ax, r) with r the root of (ay^2 + az^2) * 2^16.
    assign roll_x  = CORDIC_W'(az_reg) <<< 8;
    assign roll_y  = CORDIC_W'(ay_reg) <<< 8;
    assign pitch_x = CORDIC_W'(root_val);
    assign pitch_y = -(CORDIC_W'(ax_reg) <<< 8);

    // With ay and az both zero the accelerometer points along x alone.
    always_comb begin
        if (ax_reg > 0) begin
            pitch_flat = -DEG90_Q16;
        end else if (ax_reg < 0) begin
            pitch_flat = DEG90_Q16;
        end else begin
            pitch_flat = '0;
        end
    end

    itk_isqrt u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand ({1'b0, sq_y_reg} + {1'b0, sq_z_reg}),
        .root     (root_val),
        .busy     (root_busy)
    );

    itk_cordic u_roll_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (roll_start),
        .x_in    (roll_x),
        .y_in    (roll_y),
        .angle   (roll_angle),
        .busy    (roll_busy)
    );

    itk_cordic u_pitch_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pitch_start),
        .x_in    (pitch_x),
        .y_in    (pitch_y),
        .angle   (pitch_angle),
        .busy    (pitch_busy)
    );

    itk_kalman_lane u_pitch_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .start   (lane_start),
        .meas    (pitch_meas),
        .gyro    (gp_reg),
        .status  (pitch_st)
    );

    itk_kalman_lane u_roll_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .start   (lane_start),
        .meas    (roll_angle),
        .gyro    (gr_reg),
        .status  (roll_st)
    );

    // Sequencer of the front end and the merge into the output beat.
    always_comb begin
        state_next   = state_reg;
        root_start   = 1'b0;
        roll_start   = 1'b0;
        pitch_start  = 1'b0;
        lane_start   = 1'b0;
        pitch_meas   = pitch_angle;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        case (state_reg)
            FE_IDLE: begin
                if (in_beat) begin
                    state_next = FE_SQUARE;
                end
            end
            FE_SQUARE: begin
                state_next = FE_ROOT;
            end
            FE_ROOT: begin
                root_start = 1'b1;
                roll_start = 1'b1;
                state_next = FE_WAIT;
            end
            FE_WAIT: begin
                if (!root_busy && !roll_busy) begin
                    if (root_val == '0) begin
                        pitch_meas = pitch_flat;
                        lane_start = 1'b1;
                        state_next = FE_FILTER;
                    end else begin
                        pitch_start = 1'b1;
                        state_next  = FE_PITCH;
                    end
                end
            end
            FE_PITCH: begin
                if (!pitch_busy) begin
                    lane_start = 1'b1;
                    state_next = FE_FILTER;
                end
            end
            FE_FILTER: begin
                if (!pitch_st.busy && !roll_st.busy) begin
                    state_next = FE_OUT;
                end
            end
            FE_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, roll_st.bias, pitch_st.bias,
                                    clamp_angle(roll_st.angle), clamp_angle(pitch_st.angle)};
                    state_next   = FE_IDLE;
                end
            end
            default: begin
                state_next = FE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FE_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        if (in_beat) begin
            ax_reg <= s_tdata[15:0];
            ay_reg <= s_tdata[31:16];
            az_reg <= s_tdata[47:32];
            gp_reg <= s_tdata[63:48];
            gr_reg <= s_tdata[79:64];
        end
        if (state_reg == FE_SQUARE) begin
            sq_y_reg <= 31'(ay_reg * ay_reg);
            sq_z_reg <= 31'(az_reg * az_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/itk_isqrt.sv =====
// Digit-by-digit floor square root of (s * 2^16), two radicand bits per cycle.
module itk_isqrt import itk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic [23:0] root,
    output logic        busy
);

    logic [47:0] rad_reg, rad_next;
    logic [26:0] rem_reg, rem_next;
    logic [23:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [26:0] rem_t;
    logic [26:0] trial;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_t     = {rem_reg[24:0], rad_reg[47:46]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start) begin
            rad_next  = {radicand, 16'd0};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[45:0], 2'b00};
            if (rem_t >= trial) begin
                rem_next  = rem_t - trial;
                root_next = {root_reg[22:0], 1'b1};
            end else begin
                rem_next  = rem_t;
                root_next = {root_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign busy = busy_reg;

endmodule

// ===== rtl/core/itk_cordic.sv =====
// Iterative vectoring CORDIC giving atan2(y, x) in Q16.16 degrees, one micro-rotation a cycle.
module itk_cordic import itk_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    output logic signed [31:0]         angle,
    output logic                       busy
);

    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [31:0]         z_reg, z_next;
    logic [4:0]                 step_reg, step_next;
    logic                       busy_reg, busy_next;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        dx        = x_reg >>> step_reg;
        dy        = y_reg >>> step_reg;
        if (start) begin
            step_next = '0;
            if (x_in == '0 && y_in == '0) begin
                z_next    = '0;
                busy_next = 1'b0;
            end else begin
                busy_next = 1'b1;
                if (x_in < 0) begin
                    // Turn the vector into the right half plane first.
                    if (y_in >= 0) begin
                        x_next = y_in;
                        y_next = -x_in;
                        z_next = DEG90_Q16;
                    end else begin
                        x_next = -y_in;
                        y_next = x_in;
                        z_next = -DEG90_Q16;
                    end
                end else begin
                    x_next = x_in;
                    y_next = y_in;
                    z_next = '0;
                end
            end
        end else if (busy_reg) begin
            if (y_reg >= 0) begin
                x_next = x_reg + dy;
                y_next = y_reg - dx;
                z_next = z_reg + atan_deg(step_reg);
            end else begin
                x_next = x_reg - dy;
                y_next = y_reg + dx;
                z_next = z_reg - atan_deg(step_reg);
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign angle = z_reg;
    assign busy  = busy_reg;

endmodule

// ===== rtl/core/itk_divider.sv =====
// Restoring divider for the Kalman gain: (num * 2^24) / den truncated and saturated to 32 bits.
module itk_divider import itk_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [31:0]        den,
    output logic signed [31:0] quot,
    output logic               done
);

    logic [30:0]        lo_reg, lo_next;
    logic [32:0]        rem_reg, rem_next;
    logic [30:0]        q_reg, q_next;
    logic [31:0]        den_reg, den_next;
    logic               neg_reg, neg_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [31:0] res_reg, res_next;
    logic [31:0]        mag;
    logic [55:0]        mag56;
    logic [32:0]        rem_t;
    logic [30:0]        q_fin;

    always_comb begin
        lo_next   = lo_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        mag       = num[31] ? 32'(-num) : 32'(num);
        mag56     = {mag, 24'd0};
        rem_t     = {rem_reg[31:0], lo_reg[30]};
        q_fin     = {q_reg[29:0], 1'b0};
        if (start) begin
            den_next = den;
            neg_next = num[31];
            lo_next  = mag56[30:0];
            rem_next = {8'd0, mag56[55:31]};
            q_next   = '0;
            cnt_next = '0;
            if ({1'b0, mag56} >= {den, 31'd0}) begin
                // The quotient does not fit: saturate right away.
                res_next  = num[31] ? 32'sh80000000 : 32'sh7fffffff;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            lo_next = {lo_reg[29:0], 1'b0};
            if (rem_t >= {1'b0, den_reg}) begin
                rem_next = rem_t - {1'b0, den_reg};
                q_fin[0] = 1'b1;
            end else begin
                rem_next = rem_t;
            end
            q_next   = q_fin;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        lo_reg  <= lo_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign quot = res_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/itk_kalman_lane.sv =====
// One axis of the two-state Kalman filter: state, covariance and a sequencer over one multiplier.
module itk_kalman_lane import itk_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  kf_cfg_t            cfg,
    input  logic               start,
    input  logic signed [31:0] meas,
    input  logic signed [15:0] gyro,
    output lane_status_t       status
);

    lane_state_t        state_reg, state_next;
    lane_op_t           op_reg, op_next;
    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] bias_reg, bias_next;
    logic signed [31:0] p_reg [4];
    logic signed [31:0] p_next [4];
    logic signed [31:0] n_reg [4];
    logic signed [31:0] n_next [4];
    logic signed [31:0] rate_reg, rate_next;
    logic signed [35:0] sum_reg, sum_next;
    logic signed [31:0] k0_reg, k0_next, k1_reg, k1_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] meas_reg, meas_next;
    logic signed [15:0] gyro_reg, gyro_next;
    logic [31:0]        s_reg, s_next;
    logic signed [68:0] prod_reg;
    logic signed [35:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [32:0] dt_s;
    logic signed [71:0] prod_w, r24, dp;
    logic signed [33:0] s_full;
    logic               div_start;
    logic signed [31:0] div_num;
    logic [31:0]        div_den;
    logic signed [31:0] div_quot;
    logic               div_done;

    itk_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

    assign dt_s   = $signed({8'd0, cfg.time_step});
    assign prod_w = 72'(prod_reg);
    assign r24    = rnd_shr(prod_w, 5'd24);
    assign dp     = r24;
    assign s_full = 34'(n_reg[0]) + $signed({3'd0, cfg.measure_noise});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_RATE: begin
                mul_a = 36'(gyro_reg);
                mul_b = $signed({8'd0, cfg.gyro_gain});
            end
            OP_PRED: begin
                mul_a = 36'(rate_reg);
                mul_b = dt_s;
            end
            OP_DP: begin
                mul_a = 36'(p_reg[3]);
                mul_b = dt_s;
            end
            OP_N00: begin
                mul_a = sum_reg;
                mul_b = dt_s;
            end
            OP_N11: begin
                mul_a = $signed({5'd0, cfg.bias_noise});
                mul_b = dt_s;
            end
            OP_K0Y: begin
                mul_a = 36'(y_reg);
                mul_b = 33'(k0_reg);
            end
            OP_K1Y: begin
                mul_a = 36'(y_reg);
                mul_b = 33'(k1_reg);
            end
            OP_K0N00: begin
                mul_a = 36'(n_reg[0]);
                mul_b = 33'(k0_reg);
            end
            OP_K0N01: begin
                mul_a = 36'(n_reg[1]);
                mul_b = 33'(k0_reg);
            end
            OP_K1N00: begin
                mul_a = 36'(n_reg[0]);
                mul_b = 33'(k1_reg);
            end
            OP_K1N01: begin
                mul_a = 36'(n_reg[1]);
                mul_b = 33'(k1_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        angle_next = angle_reg;
        bias_next  = bias_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        rate_next  = rate_reg;
        sum_next   = sum_reg;
        k0_next    = k0_reg;
        k1_next    = k1_reg;
        y_next     = y_reg;
        meas_next  = meas_reg;
        gyro_next  = gyro_reg;
        s_next     = s_reg;
        div_start  = 1'b0;
        div_num    = n_reg[0];
        div_den    = s_reg;
        case (state_reg)
            LN_IDLE: begin
                if (start) begin
                    meas_next  = meas;
                    gyro_next  = gyro;
                    op_next    = OP_RATE;
                    state_next = LN_MUL;
                end
            end
            LN_MUL: begin
                state_next = LN_ACC;
            end
            LN_ACC: begin
                state_next = LN_MUL;
                case (op_reg)
                    OP_RATE: begin
                        rate_next = sat32(72'(sat32(rnd_shr(prod_w, 5'd8))) - 72'(bias_reg));
                        op_next   = OP_PRED;
                    end
                    OP_PRED: begin
                        angle_next = sat32(72'(angle_reg) + r24);
                        op_next    = OP_DP;
                    end
                    OP_DP: begin
                        n_next[1] = sat32(72'(p_reg[1]) - dp);
                        n_next[2] = sat32(72'(p_reg[2]) - dp);
                        sum_next  = 36'(dp - 72'(p_reg[1]) - 72'(p_reg[2])
                                    + $signed({41'd0, cfg.angle_noise}));
                        op_next   = OP_N00;
                    end
                    OP_N00: begin
                        n_next[0] = sat32(72'(p_reg[0]) + r24);
                        op_next   = OP_N11;
                    end
                    OP_N11: begin
                        n_next[3] = sat32(72'(p_reg[3]) + r24);
                        s_next    = s_full[31:0];
                        if (s_full > 0) begin
                            div_start  = 1'b1;
                            div_num    = n_reg[0];
                            div_den    = s_full[31:0];
                            state_next = LN_DIV0;
                        end else begin
                            // No usable innovation variance: keep the prediction.
                            p_next[0]  = n_reg[0];
                            p_next[1]  = n_reg[1];
                            p_next[2]  = n_reg[2];
                            p_next[3]  = sat32(72'(p_reg[3]) + r24);
                            state_next = LN_IDLE;
                        end
                    end
                    OP_K0Y: begin
                        angle_next = sat32(72'(angle_reg) + r24);
                        op_next    = OP_K1Y;
                    end
                    OP_K1Y: begin
                        bias_next = sat32(72'(bias_reg) + r24);
                        op_next   = OP_K0N00;
                    end
                    OP_K0N00: begin
                        p_next[0] = sat32(72'(n_reg[0]) - r24);
                        op_next   = OP_K0N01;
                    end
                    OP_K0N01: begin
                        p_next[1] = sat32(72'(n_reg[1]) - r24);
                        op_next   = OP_K1N00;
                    end
                    OP_K1N00: begin
                        p_next[2] = sat32(72'(n_reg[2]) - r24);
                        op_next   = OP_K1N01;
                    end
                    OP_K1N01: begin
                        p_next[3]  = sat32(72'(n_reg[3]) - r24);
                        state_next = LN_IDLE;
                    end
                    default: begin
                        state_next = LN_IDLE;
                    end
                endcase
            end
            LN_DIV0: begin
                if (div_done) begin
                    k0_next    = div_quot;
                    div_start  = 1'b1;
                    div_num    = n_reg[2];
                    div_den    = s_reg;
                    state_next = LN_DIV1;
                end
            end
            LN_DIV1: begin
                if (div_done) begin
                    k1_next    = div_quot;
                    y_next     = sat32(72'(meas_reg) - 72'(angle_reg));
                    op_next    = OP_K0Y;
                    state_next = LN_MUL;
                end
            end
            default: begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
            op_reg    <= OP_RATE;
            angle_reg <= '0;
            bias_reg  <= '0;
            for (int i = 0; i < 4; i++) begin
                p_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            angle_reg <= angle_next;
            bias_reg  <= bias_next;
            p_reg     <= p_next;
        end
        if (state_reg == LN_MUL) begin
            prod_reg <= mul_a * mul_b;
        end
        n_reg    <= n_next;
        rate_reg <= rate_next;
        sum_reg  <= sum_next;
        k0_reg   <= k0_next;
        k1_reg   <= k1_next;
        y_reg    <= y_next;
        meas_reg <= meas_next;
        gyro_reg <= gyro_next;
        s_reg    <= s_next;
    end

    assign status.busy  = (state_reg != LN_IDLE);
    assign status.angle = angle_reg;
    assign status.bias  = bias_reg;

endmodule

// ===== rtl/core/itk_checker.sv =====
// Port-level checker for the IMU tilt Kalman filter core, bound to the top level.
module itk_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [119:0]          m_tdata
);

    // A waiting result beat keeps its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // One sample at a time: the input closes right after a beat.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is in flight");

    // Reported angles never exceed the 360 degree limit.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[25:0]) <= 26'sd23592960)
                  && ($signed(m_tdata[25:0]) >= -26'sd23592960)
                  && ($signed(m_tdata[51:26]) <= 26'sd23592960)
                  && ($signed(m_tdata[51:26]) >= -26'sd23592960))
        else $error("angle outside the clamp range");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

endmodule

bind imu_tilt_kalman_filter_core itk_checker u_itk_checker (.*);

// ===== sim/tb_imu_tilt_kalman_filter_core.sv =====
// Self-checking testbench of the IMU tilt Kalman filter core with a built-in filter predictor.
module tb_imu_tilt_kalman_filter_core;
    import itk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Raw sample as it travels on s_tdata, lowest field first.
    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gp;
        logic signed [15:0] gr;
    } imu_sample_t;

    // Fields of the filter output beat carried on m_tdata.
    typedef struct packed {
        logic [25:0] pitch;
        logic [25:0] roll;
        logic [31:0] pitch_bias;
        logic [31:0] roll_bias;
    } tilt_result_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [79:0]   s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [119:0]  m_tdata;
    logic          cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    imu_tilt_kalman_filter_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    // Predictor state: its own copy of the filter registers and per-axis states.
    longint        noise_angle, noise_bias, noise_meas, step_dt, gain_gyro;
    longint        est_angle [2];
    longint        est_bias [2];
    longint        cov [2][4];

    imu_sample_t   send_queue[$];
    tilt_result_t  expected_results[$];
    int            mismatch_count = 0;
    bit            sender_enable;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // A separate watchdog; the slowest correct run is far below this limit.
    initial begin
        #50ms;
        $display("tb_imu_tilt_kalman_filter_core failed");
        $finish;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_entry(int i);
        case (i)
            0: return 2949120;   1: return 1740967;  2: return 919879;   3: return 466945;
            4: return 234379;    5: return 117266;   6: return 58666;    7: return 29335;
            8: return 14668;     9: return 7334;     10: return 3667;    11: return 1833;
            12: return 917;      13: return 458;     14: return 229;     15: return 115;
            16: return 57;       17: return 29;      18: return 14;      19: return 7;
            20: return 4;        21: return 2;       22: return 1;
            default: return 0;
        endcase
    endfunction

    // Vectoring-mode CORDIC angle of (x, y) in Q16.16 degrees.
    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 5898240;
            end else begin
                t = x; x = -y; y = t; z = -5898240;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = asr(x, i);
            dy = asr(y, i);
            if (y >= 0) begin
                x += dy; y -= dx; z += atan_entry(i);
            end else begin
                x -= dy; y += dx; z -= atan_entry(i);
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned rem, res, b;
        rem = v; res = 0; b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Predict and correct one axis; covariance order is P00, P01, P10, P11.
    function automatic void filter_axis(int k, longint meas, longint gyro);
        longint rate, dp11, n00, n01, n10, n11, s, k0, k1, innov;
        rate = clip32(round_shift(gyro * gain_gyro, 8));
        rate = clip32(rate - est_bias[k]);
        est_angle[k] = clip32(est_angle[k] + round_shift(step_dt * rate, 24));
        dp11 = round_shift(step_dt * cov[k][3], 24);
        n00 = clip32(cov[k][0] + round_shift(step_dt * (dp11 - cov[k][1] - cov[k][2]
              + noise_angle), 24));
        n01 = clip32(cov[k][1] - dp11);
        n10 = clip32(cov[k][2] - dp11);
        n11 = clip32(cov[k][3] + round_shift(noise_bias * step_dt, 24));
        s = n00 + noise_meas;
        if (s > 0) begin
            k0 = clip32((n00 * 16777216) / s);
            k1 = clip32((n10 * 16777216) / s);
            innov = clip32(meas - est_angle[k]);
            est_angle[k] = clip32(est_angle[k] + round_shift(k0 * innov, 24));
            est_bias[k] = clip32(est_bias[k] + round_shift(k1 * innov, 24));
            cov[k][0] = clip32(n00 - round_shift(k0 * n00, 24));
            cov[k][1] = clip32(n01 - round_shift(k0 * n01, 24));
            cov[k][2] = clip32(n10 - round_shift(k1 * n00, 24));
            cov[k][3] = clip32(n11 - round_shift(k1 * n01, 24));
        end else begin
            cov[k][0] = n00; cov[k][1] = n01; cov[k][2] = n10; cov[k][3] = n11;
        end
    endfunction

    function automatic logic [25:0] limit_angle(longint a);
        longint v;
        v = a;
        if (v > 23592960) v = 23592960;
        if (v < -23592960) v = -23592960;
        return v[25:0];
    endfunction

    // Runs one sample through the predictor and returns the expected beat.
    function automatic tilt_result_t predict_tilt(imu_sample_t smp);
        longint ax, ay, az, roll_meas, pitch_meas;
        longint unsigned rr;
        tilt_result_t res;
        ax = smp.ax; ay = smp.ay; az = smp.az;
        roll_meas = vector_angle(ay * 256, az * 256);
        rr = floor_sqrt((ay * ay + az * az) * 65536);
        if (rr == 0) begin
            pitch_meas = ax > 0 ? -5898240 : (ax < 0 ? 5898240 : 0);
        end else begin
            pitch_meas = vector_angle(-ax * 256, longint'(rr));
        end
        filter_axis(0, pitch_meas, longint'(smp.gp));
        filter_axis(1, roll_meas, longint'(smp.gr));
        res.pitch = limit_angle(est_angle[0]);
        res.roll = limit_angle(est_angle[1]);
        res.pitch_bias = est_bias[0][31:0];
        res.roll_bias = est_bias[1][31:0];
        return res;
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 7)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic imu_sample_t random_sample();
        imu_sample_t smp;
        smp.ax = rand_axis();
        // Mostly a plausible gravity vector so the filter settles; some raw noise too.
        if ($urandom_range(0, 3) != 0) begin
            smp.ay = 16'($signed($urandom_range(0, 8000)) - 4000);
            smp.az = 16'($signed($urandom_range(0, 32000)) - 16000);
            smp.gp = 16'($signed($urandom_range(0, 2000)) - 1000);
            smp.gr = 16'($signed($urandom_range(0, 2000)) - 1000);
        end else begin
            smp.ay = rand_axis();
            smp.az = rand_axis();
            smp.gp = rand_axis();
            smp.gr = rand_axis();
        end
        return smp;
    endfunction

    function automatic imu_sample_t make_sample(int ax, int ay, int az, int gp, int gr);
        imu_sample_t smp;
        smp.ax = 16'(ax); smp.ay = 16'(ay); smp.az = 16'(az);
        smp.gp = 16'(gp); smp.gr = 16'(gr);
        return smp;
    endfunction

    // Driver: takes beats from the send queue, with random gaps between them.
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_left <= 0;
        end else if (s_tvalid && !s_tready) begin
            // Hold the beat until the block takes it.
        end else if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (sender_enable && send_queue.size() > 0) begin
            imu_sample_t smp;
            smp = send_queue.pop_front();
            expected_results.push_back(predict_tilt(smp));
            s_tdata <= {smp.gr, smp.gp, smp.az, smp.ay, smp.ax};
            s_tvalid <= 1'b1;
            case ($urandom_range(0, 9))
                0: gap_left <= $urandom_range(20, 300);
                1, 2, 3: gap_left <= $urandom_range(1, 6);
                default: gap_left <= 0;
            endcase
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Monitor: compares each result beat with the oldest expectation, and stalls at random.
    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                tilt_result_t got, want;
                got.pitch = m_tdata[25:0];
                got.roll = m_tdata[51:26];
                got.pitch_bias = m_tdata[83:52];
                got.roll_bias = m_tdata[115:84];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (got != want || m_tdata[119:116] != 4'd0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp pitch %h roll %h pb %h rb %h, got %h %h %h %h",
                                     want.pitch, want.roll, want.pitch_bias, want.roll_bias,
                                     got.pitch, got.roll, got.pitch_bias, got.roll_bias);
                    end
                end
            end
            if (stall_left > 0) begin
                // A long stall of the receiver.
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                case ($urandom_range(0, 63))
                    0: begin
                        m_tready <= 1'b0;
                        stall_left <= $urandom_range(20, 200);
                    end
                    1, 2, 3, 4: m_tready <= 1'b0;
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Writes one filter register into both the block and the predictor.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, longint value);
        cfg_index <= idx;
        cfg_wr_data <= value[CFG_DATA_W-1:0];
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ANGLE_NOISE:   noise_angle = value & 64'h7fffffff;
            CFG_BIAS_NOISE:    noise_bias = value & 64'h7fffffff;
            CFG_MEASURE_NOISE: noise_meas = value & 64'h7fffffff;
            CFG_TIME_STEP:     step_dt = value & 64'h1ffffff;
            CFG_GYRO_GAIN:     gain_gyro = value & 64'h1ffffff;
            default: ;
        endcase
    endtask

    // Lets every queued sample through and waits for the block to go quiet.
    task automatic drain();
        sender_enable = 1'b1;
        wait (send_queue.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (200) @(posedge aclk);
        sender_enable = 1'b0;
    endtask

    task automatic queue_random(int count);
        repeat (count) send_queue.push_back(random_sample());
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        sender_enable = 1'b0;
        noise_angle = 16777; noise_bias = 50332; noise_meas = 503316;
        step_dt = 167772; gain_gyro = 128071;
        for (int k = 0; k < 2; k++) begin
            est_angle[k] = 0; est_bias[k] = 0;
            for (int j = 0; j < 4; j++) cov[k][j] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with default settings: field extremes and the level and flat cases.
        send_queue.push_back(make_sample(0, 0, 0, 0, 0));
        send_queue.push_back(make_sample(100, 0, 0, 0, 0));
        send_queue.push_back(make_sample(-100, 0, 0, 0, 0));
        send_queue.push_back(make_sample(0, 0, 16384, 0, 0));
        send_queue.push_back(make_sample(0, 16384, 0, 0, 0));
        send_queue.push_back(make_sample(0, 0, -16384, 0, 0));
        send_queue.push_back(make_sample(0, -16384, -1, 0, 0));
        send_queue.push_back(make_sample(-32768, -32768, -32768, -32768, -32768));
        send_queue.push_back(make_sample(32767, 32767, 32767, 32767, 32767));
        send_queue.push_back(make_sample(32767, -32768, 32767, -32768, 32767));
        send_queue.push_back(make_sample(-32768, 1, -1, 32767, -32768));
        send_queue.push_back(make_sample(-1, -1, -1, -1, -1));
        queue_random(150);
        drain();

        // Extremes: largest noises, time step and gyro gain, then a negative innovation variance is
        // impossible, so also the smallest values to keep the filter nearly frozen.
        write_register(CFG_ANGLE_NOISE, 64'h7fffffff);
        write_register(CFG_BIAS_NOISE, 64'h7fffffff);
        write_register(CFG_MEASURE_NOISE, 64'h7fffffff);
        write_register(CFG_TIME_STEP, 16777216);
        write_register(CFG_GYRO_GAIN, 16777216);
        // An index beyond the last register must be ignored.
        write_register(3'd7, 64'h12345);
        send_queue.push_back(make_sample(32767, 32767, 32767, 32767, 32767));
        send_queue.push_back(make_sample(-32768, -32768, -32768, -32768, -32768));
        queue_random(120);
        drain();

        write_register(CFG_ANGLE_NOISE, 0);
        write_register(CFG_BIAS_NOISE, 0);
        write_register(CFG_MEASURE_NOISE, 1);
        write_register(CFG_TIME_STEP, 1);
        write_register(CFG_GYRO_GAIN, 1);
        queue_random(120);
        drain();

        // Random settings between phases.
        repeat (3) begin
            write_register(CFG_ANGLE_NOISE, $urandom_range(0, 32'h7fffffff));
            write_register(CFG_BIAS_NOISE, $urandom_range(0, 32'h7fffffff));
            write_register(CFG_MEASURE_NOISE, $urandom_range(1, 32'h7fffffff));
            write_register(CFG_TIME_STEP, $urandom_range(1, 16777216));
            write_register(CFG_GYRO_GAIN, $urandom_range(1, 16777216));
            queue_random(60);
            drain();
        end

        // Back to typical values for a long settled run.
        write_register(CFG_ANGLE_NOISE, 16777);
        write_register(CFG_BIAS_NOISE, 50332);
        write_register(CFG_MEASURE_NOISE, 503316);
        write_register(CFG_TIME_STEP, 167772);
        write_register(CFG_GYRO_GAIN, 128071);
        queue_random(80);
        drain();

        if (mismatch_count == 0) begin
            $display("tb_imu_tilt_kalman_filter_core passed");
        end else begin
            $display("tb_imu_tilt_kalman_filter_core failed");
        end
        $finish;
    end

endmodule
